[rtl/cpsp_pkg.sv]
// Package for the cascaded position/speed PID block.
// Holds register indexes, action codes, widths and shared types. No dependencies.
package cpsp_pkg;
    localparam int ANGLE_BITS   = 13;
    localparam int TURN_BITS    = 19;
    localparam int POS_DEADBAND = 0;
    localparam int SPD_DEADBAND = 0;
    localparam int GAIN_BITS    = 16;
    localparam int LIM_BITS     = 15;
    localparam int ERR_BITS     = 32;
    localparam int ACC_BITS     = 52;
    localparam int CNT_BITS     = 5;

    localparam logic [2:0] REG_POS_KP = 3'd0;
    localparam logic [2:0] REG_POS_KI = 3'd1;
    localparam logic [2:0] REG_POS_KD = 3'd2;
    localparam logic [2:0] REG_SPD_KP = 3'd3;
    localparam logic [2:0] REG_SPD_KI = 3'd4;
    localparam logic [2:0] REG_SPD_KD = 3'd5;
    localparam logic [2:0] REG_POS_LIM = 3'd6;
    localparam logic [2:0] REG_SPD_LIM = 3'd7;

    localparam logic [1:0] ACT_MULTI  = 2'd0;
    localparam logic [1:0] ACT_SINGLE = 2'd1;
    localparam logic [1:0] ACT_SPEED  = 2'd2;
    localparam logic [1:0] ACT_DIRECT = 2'd3;

    localparam logic [14:0] LIMIT_RESET = 15'd1000;

    typedef struct packed {
        logic [GAIN_BITS-1:0] kp;
        logic [GAIN_BITS-1:0] ki;
        logic [GAIN_BITS-1:0] kd;
        logic [LIM_BITS-1:0]  lim;
    } t_gains;

    typedef struct packed {
        logic [1:0]           action;
        logic signed [31:0]   target;
        logic [ANGLE_BITS-1:0] angle;
        logic signed [15:0]   speed;
        logic                 fresh;
    } t_in;

    typedef struct packed {
        logic signed [15:0] current_command;
        logic               command_valid;
        logic signed [15:0] speed_setpoint;
        logic signed [31:0] total_position;
    } t_out;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sd2147483647) return 32'sh7FFFFFFF;
        else if (v < -34'sd2147483648) return 32'sh80000000;
        else return v[31:0];
    endfunction
endpackage

[rtl/cpsp_if.sv]
// Valid/ready channel interfaces for the cascaded PID block.
// Depends on cpsp_pkg for payload types.
interface cpsp_in_if;
    logic          valid;
    logic          ready;
    cpsp_pkg::t_in data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cpsp_out_if;
    logic           valid;
    logic           ready;
    cpsp_pkg::t_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cpsp_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

[rtl/cascade_position_speed_pid.sv]
// Top level of the cascaded position/speed PID block.
// Depends on cpsp_pkg, cpsp_if, cpsp_pid and cpsp_unwrap.
//  channel | dir | fields
//  in_ch   | in  | action, target, measured_angle, measured_speed, feedback_fresh
//  out_ch  | out | current_command, command_valid, speed_setpoint, total_position
//  cfg_ch  | in  | index (0..7), wdata
// A position tick takes two serial PID passes, position then speed, each a shift-add
// over the 16 gain bits; speed mode takes only the speed pass and direct current none.
// in_ch is ready again from the cycle the result appears.
// Synchronous active-low reset zeroes gains and loop state and sets both limits to 1000.
// A held result lets the next transaction run its PID passes; that transaction then
// waits at the output stage until out_ch is taken.
module cascade_position_speed_pid (
    input  logic i_clk,
    input  logic i_rst_n,
    cpsp_in_if.sink    in_ch,
    cpsp_out_if.source out_ch,
    cpsp_cfg_if.sink   cfg_ch
);
    localparam logic [2:0] ST_IDLE = 3'd0, ST_POS = 3'd1, ST_SPD = 3'd2,
                           ST_OUT = 3'd3, ST_WPOS = 3'd4, ST_WSPD = 3'd5,
                           ST_LOAD = 3'd6;
    logic [2:0] r_st;
    cpsp_pkg::t_in r_in;
    cpsp_pkg::t_gains r_pg, r_sg;
    logic r_armed;
    logic signed [15:0] r_sp;
    logic signed [15:0] r_cmd;
    logic r_cmdv;
    logic r_valid;
    cpsp_pkg::t_out r_res;
    logic pos_go, spd_go, pos_done, spd_done;
    logic signed [15:0] pos_out, spd_out;
    logic signed [31:0] mt_pos;
    logic signed [33:0] pos_act, spd_tgt;
    logic unw_en;

    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pg <= '{16'd0, 16'd0, 16'd0, cpsp_pkg::LIMIT_RESET};
            r_sg <= '{16'd0, 16'd0, 16'd0, cpsp_pkg::LIMIT_RESET};
        end else if (cfg_ch.valid) begin
            unique case (cfg_ch.index)
                cpsp_pkg::REG_POS_KP:  r_pg.kp  <= cfg_ch.wdata;
                cpsp_pkg::REG_POS_KI:  r_pg.ki  <= cfg_ch.wdata;
                cpsp_pkg::REG_POS_KD:  r_pg.kd  <= cfg_ch.wdata;
                cpsp_pkg::REG_SPD_KP:  r_sg.kp  <= cfg_ch.wdata;
                cpsp_pkg::REG_SPD_KI:  r_sg.ki  <= cfg_ch.wdata;
                cpsp_pkg::REG_SPD_KD:  r_sg.kd  <= cfg_ch.wdata;
                cpsp_pkg::REG_POS_LIM: r_pg.lim <= cfg_ch.wdata[14:0];
                cpsp_pkg::REG_SPD_LIM: r_sg.lim <= cfg_ch.wdata[14:0];
                default: ;
            endcase
        end
    end

    assign in_ch.ready  = (r_st == ST_IDLE);
    assign out_ch.valid = r_valid;
    assign out_ch.data  = r_res;

    assign pos_act = (r_in.action == cpsp_pkg::ACT_MULTI) ? 34'(mt_pos)
                   : 34'({1'b0, r_in.angle});
    assign spd_tgt = (r_in.action == cpsp_pkg::ACT_SPEED) ? 34'(r_in.target)
                   : 34'(pos_out);
    assign pos_go = (r_st == ST_POS);
    assign spd_go = (r_st == ST_SPD);
    // Advance the unwrap once, as the tick leaves the output stage.
    assign unw_en = (r_st == ST_OUT) && !r_valid;

    cpsp_pid u_pos (.i_clk, .i_rst_n, .i_start(pos_go), .i_tgt(34'(r_in.target)),
        .i_act(pos_act), .i_gains(r_pg), .i_dband(32'(cpsp_pkg::POS_DEADBAND)),
        .o_done(pos_done), .o_out(pos_out));
    cpsp_pid u_spd (.i_clk, .i_rst_n, .i_start(spd_go), .i_tgt(spd_tgt),
        .i_act(34'(r_in.speed)), .i_gains(r_sg), .i_dband(32'(cpsp_pkg::SPD_DEADBAND)),
        .o_done(spd_done), .o_out(spd_out));
    cpsp_unwrap u_unw (.i_clk, .i_rst_n, .i_en(unw_en), .i_angle(r_in.angle),
        .o_pos(mt_pos));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_armed <= 1'b0; r_valid <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) r_valid <= 1'b0;
            unique case (r_st)
                ST_IDLE: if (in_ch.valid) begin
                    r_in <= in_ch.data;
                    if (in_ch.data.fresh) r_armed <= 1'b1;
                    r_sp <= '0;
                    priority if (in_ch.data.action == cpsp_pkg::ACT_DIRECT) begin
                        r_cmd <= in_ch.data.target[15:0];
                        r_cmdv <= 1'b1;
                        r_st <= ST_OUT;
                    end else if (in_ch.data.action == cpsp_pkg::ACT_SPEED) r_st <= ST_SPD;
                    else r_st <= ST_POS;
                end
                ST_POS:  r_st <= ST_WPOS;
                ST_WPOS: if (pos_done) begin r_sp <= pos_out; r_st <= ST_SPD; end
                ST_SPD:  r_st <= ST_WSPD;
                ST_WSPD: if (spd_done) begin
                    r_cmd <= r_armed ? spd_out : 16'sd0;
                    r_cmdv <= r_armed;
                    r_armed <= 1'b0;
                    r_st <= ST_OUT;
                end
                ST_OUT: if (!r_valid) begin
                    r_st <= ST_LOAD;
                end
                ST_LOAD: begin
                    r_res.current_command <= r_cmd;
                    r_res.command_valid <= r_cmdv;
                    r_res.speed_setpoint <= r_sp;
                    r_res.total_position <= mt_pos;
                    r_valid <= 1'b1;
                    r_st <= ST_IDLE;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end
endmodule

[rtl/cpsp_pid.sv]
// One PID evaluation: Kp*e + Ki*I + Kd*de by bit-serial gain multiply,
// then floor /256, clamp with integral back-off. Depends on cpsp_pkg.
module cpsp_pid (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [33:0]   i_tgt,
    input  logic signed [33:0]   i_act,
    input  cpsp_pkg::t_gains     i_gains,
    input  logic [31:0]          i_dband,
    output logic                 o_done,
    output logic signed [15:0]   o_out
);
    logic                 r_busy, n_busy;
    logic [4:0]           r_cnt, n_cnt;
    logic signed [31:0]   r_err, r_ni, r_old, r_prev, r_integ;
    logic signed [33:0]   r_de_full;
    logic [15:0]          r_kp, r_ki, r_kd;
    logic signed [cpsp_pkg::ACC_BITS-1:0] r_acc, n_acc;
    logic signed [cpsp_pkg::LIM_BITS:0]   r_out;
    logic                 r_done;

    logic signed [31:0]   err_c, ni_c;
    logic signed [cpsp_pkg::ACC_BITS-1:0] term, res;
    logic signed [cpsp_pkg::ACC_BITS-9:0] q;
    logic signed [cpsp_pkg::LIM_BITS+1:0] lim_s;

    assign err_c = cpsp_pkg::sat32(i_tgt - i_act);
    assign ni_c  = cpsp_pkg::sat32(34'(r_integ) + 34'(err_c));

    // Shift-add over the gain bits, one bit of all three gains per cycle.
    always_comb begin
        term = '0;
        if (r_kp[15]) term = term + cpsp_pkg::ACC_BITS'(r_err);
        if (r_ki[15]) term = term + cpsp_pkg::ACC_BITS'(r_ni);
        if (r_kd[15]) term = term + cpsp_pkg::ACC_BITS'(r_de_full);
        n_acc = (r_acc <<< 1) + term;
        n_busy = r_busy;
        n_cnt  = r_cnt;
        if (r_busy) begin
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd1) n_busy = 1'b0;
        end
    end

    assign res   = r_acc;
    assign q     = res[cpsp_pkg::ACC_BITS-1:8];
    assign lim_s = {2'b00, i_gains.lim};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
            r_done <= 1'b0;
            r_integ <= '0;
            r_prev <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 5'd1);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= 5'd16;
                r_err <= err_c;
                r_old <= r_integ;
                r_ni <= ni_c;
                r_de_full <= 34'(err_c) - 34'(r_prev);
                r_kp <= i_gains.kp;
                r_ki <= i_gains.ki;
                r_kd <= i_gains.kd;
                r_acc <= '0;
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_kp <= r_kp << 1;
                r_ki <= r_ki << 1;
                r_kd <= r_kd << 1;
                r_cnt <= n_cnt;
                r_busy <= n_busy;
                if (r_cnt == 5'd1) r_prev <= r_err;
            end
            if (r_done) begin
                // Clamp the floored sum; a clamp keeps the old integral.
                if (q > (cpsp_pkg::ACC_BITS-8)'(lim_s)) begin
                    r_out <= lim_s[cpsp_pkg::LIM_BITS:0];
                    r_integ <= r_old;
                end else if (q < -(cpsp_pkg::ACC_BITS-8)'(lim_s)) begin
                    r_out <= -lim_s[cpsp_pkg::LIM_BITS:0];
                    r_integ <= r_old;
                end else begin
                    r_out <= q[cpsp_pkg::LIM_BITS:0];
                    r_integ <= r_ni;
                end
            end
        end
    end

    logic r_fin;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_fin <= 1'b0;
        else r_fin <= r_done;
    end

    logic [31:0] mag;
    assign mag = r_prev[31] ? -r_prev : r_prev;
    assign o_done = r_fin;
    assign o_out  = (mag < i_dband) ? 16'sd0 : 16'(r_out);
endmodule

[rtl/cpsp_unwrap.sv]
// Angle unwrap: turn counter and multi-turn position register.
// Depends on cpsp_pkg.
module cpsp_unwrap (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic [cpsp_pkg::ANGLE_BITS-1:0] i_angle,
    output logic signed [31:0]             o_pos
);
    logic [cpsp_pkg::TURN_BITS-1:0]  r_turn, n_turn;
    logic [cpsp_pkg::ANGLE_BITS-1:0] r_prev;
    logic signed [31:0]              r_pos;
    logic signed [cpsp_pkg::ANGLE_BITS+1:0] diff;
    localparam logic signed [cpsp_pkg::ANGLE_BITS+1:0] HALF =
        (cpsp_pkg::ANGLE_BITS+2)'(1) <<< (cpsp_pkg::ANGLE_BITS-1);

    assign diff = $signed({2'b00, i_angle}) - $signed({2'b00, r_prev});
    always_comb begin
        n_turn = r_turn;
        if (diff > HALF) n_turn = r_turn - 1'b1;
        else if (diff < -HALF) n_turn = r_turn + 1'b1;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn <= '0; r_prev <= '0; r_pos <= '0;
        end else if (i_en) begin
            r_turn <= n_turn;
            r_prev <= i_angle;
            r_pos  <= 32'({n_turn, i_angle});
        end
    end
    assign o_pos = r_pos;
endmodule
